### design/inv3_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// inv3_pkg
// Shared widths, payload types and cofactor index table for the 3x3 inverse.
// ---------------------------------------------------------------------------
package inv3_pkg;

   localparam int ELEM_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int EW = ELEM_WIDTH;
   localparam int PW = 2 * EW;
   localparam int CW = PW + 1;
   localparam int HW = CW - EW;
   localparam int MW = EW + HW;
   localparam int TW = EW + CW;
   localparam int DW = TW + 2;
   localparam int NW = CW + 2 * FRAC_BITS;
   localparam int QB = EW;
   localparam int RW = DW + QB;

   localparam int COF_LAT  = 2;
   localparam int DET_LAT  = 3;
   localparam int LANE_LAT = QB + 2;
   localparam int LAT      = COF_LAT + DET_LAT + LANE_LAT;

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [CW-1:0] cof_type;
   typedef logic signed [DW-1:0] det_type;

   typedef struct packed {
      elem_type a00;
      elem_type a01;
      elem_type a02;
      elem_type a10;
      elem_type a11;
      elem_type a12;
      elem_type a20;
      elem_type a21;
      elem_type a22;
   } req_type;

   typedef struct packed {
      elem_type b00;
      elem_type b01;
      elem_type b02;
      elem_type b10;
      elem_type b11;
      elem_type b12;
      elem_type b20;
      elem_type b21;
      elem_type b22;
      logic     singular;
      logic     overflow;
   } rsp_type;

   // Cofactor k is a[p]*a[q] - a[r]*a[s], already transposed.
   localparam logic [3:0] COF_IDX [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage
`default_nettype wire

### design/inv3_cof.sv
`default_nettype none
// ---------------------------------------------------------------------------
// inv3_cof
// Two-stage cofactor unit: eighteen products, then nine differences.
// ---------------------------------------------------------------------------
module inv3_cof (
   input  wire logic              clock,
   input  wire inv3_pkg::req_type req_data,
   output inv3_pkg::cof_type      cof [9],
   output inv3_pkg::elem_type     row [3]
);
   import inv3_pkg::*;

   elem_type               a      [9];
   logic signed [PW-1:0]   pa_ff  [9];
   logic signed [PW-1:0]   pb_ff  [9];
   cof_type                cof_ff [9];
   elem_type               row1_ff [3];
   elem_type               row2_ff [3];

   assign a[0] = req_data.a00;
   assign a[1] = req_data.a01;
   assign a[2] = req_data.a02;
   assign a[3] = req_data.a10;
   assign a[4] = req_data.a11;
   assign a[5] = req_data.a12;
   assign a[6] = req_data.a20;
   assign a[7] = req_data.a21;
   assign a[8] = req_data.a22;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         pa_ff[i]  <= a[COF_IDX[i][0]] * a[COF_IDX[i][1]];
         pb_ff[i]  <= a[COF_IDX[i][2]] * a[COF_IDX[i][3]];
         cof_ff[i] <= CW'(pa_ff[i]) - CW'(pb_ff[i]);
      end
      for (int j = 0; j < 3; j++) begin
         row1_ff[j] <= a[j];
         row2_ff[j] <= row1_ff[j];
      end
   end

   assign cof = cof_ff;
   assign row = row2_ff;

endmodule
`default_nettype wire

### design/inv3_det.sv
`default_nettype none
// ---------------------------------------------------------------------------
// inv3_det
// Three-stage determinant along the first row; cofactors ride alongside.
// ---------------------------------------------------------------------------
module inv3_det (
   input  wire logic               clock,
   input  wire inv3_pkg::cof_type  cof_i [9],
   input  wire inv3_pkg::elem_type row [3],
   output inv3_pkg::cof_type       cof_o [9],
   output inv3_pkg::det_type       det
);
   import inv3_pkg::*;

   logic signed [MW-1:0] lo_ff   [3];
   logic signed [MW-1:0] hi_ff   [3];
   logic signed [TW-1:0] term_ff [3];
   det_type              det_ff;
   cof_type              c1_ff [9];
   cof_type              c2_ff [9];
   cof_type              c3_ff [9];

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         lo_ff[j]   <= row[j] * $signed({1'b0, cof_i[3*j][EW-1:0]});
         hi_ff[j]   <= row[j] * $signed(cof_i[3*j][CW-1:EW]);
         term_ff[j] <= (TW'(hi_ff[j]) <<< EW) + TW'(lo_ff[j]);
      end
      det_ff <= DW'(term_ff[0]) + DW'(term_ff[1]) + DW'(term_ff[2]);
      for (int i = 0; i < 9; i++) begin
         c1_ff[i] <= cof_i[i];
         c2_ff[i] <= c1_ff[i];
         c3_ff[i] <= c2_ff[i];
      end
   end

   assign cof_o = c3_ff;
   assign det   = det_ff;

endmodule
`default_nettype wire

### design/inv3_div_lane.sv
`default_nettype none
// ---------------------------------------------------------------------------
// inv3_div_lane
// One output element: sign split, one quotient bit per stage, saturation.
// ---------------------------------------------------------------------------
module inv3_div_lane (
   input  wire logic              clock,
   input  wire inv3_pkg::cof_type cof,
   input  wire inv3_pkg::det_type det,
   output inv3_pkg::elem_type     elem,
   output logic                   sat,
   output logic                   zero_det
);
   import inv3_pkg::*;

   logic              cneg;
   logic              dneg;
   logic [CW-1:0]     cmag;
   logic [DW-1:0]     dmag;
   logic [NW-1:0]     num;

   logic [RW-1:0]     rem_ff  [QB+1];
   logic [QB-1:0]     q_ff    [QB+1];
   logic [DW-1:0]     d_ff    [QB+1];
   logic              neg_ff  [QB+1];
   logic              big_ff  [QB+1];
   logic              dz_ff   [QB+1];

   elem_type          elem_ff;
   logic              sat_ff;
   logic              dz_out_ff;

   assign cneg = cof[CW-1];
   assign dneg = det[DW-1];
   assign cmag = cneg ? CW'(-cof) : CW'(cof);
   assign dmag = dneg ? DW'(-det) : DW'(det);
   assign num  = {cmag, {(2*FRAC_BITS){1'b0}}};

   always_ff @(posedge clock) begin
      rem_ff[0] <= RW'(num);
      q_ff[0]   <= '0;
      d_ff[0]   <= dmag;
      neg_ff[0] <= cneg ^ dneg;
      big_ff[0] <= RW'(num) >= (RW'(dmag) << QB);
      dz_ff[0]  <= (dmag == '0);
   end

   for (genvar i = 0; i < QB; i++) begin : g_stage
      localparam int K = QB - 1 - i;
      logic [RW-1:0] trial;
      logic          take;

      assign trial = RW'(d_ff[i]) << K;
      assign take  = rem_ff[i] >= trial;

      always_ff @(posedge clock) begin
         rem_ff[i+1] <= take ? rem_ff[i] - trial : rem_ff[i];
         q_ff[i+1]   <= q_ff[i] | (QB'(take) << K);
         d_ff[i+1]   <= d_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         big_ff[i+1] <= big_ff[i];
         dz_ff[i+1]  <= dz_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      dz_out_ff <= dz_ff[QB];
      if (dz_ff[QB]) begin
         elem_ff <= '0;
         sat_ff  <= 1'b0;
      end else if (big_ff[QB] ||
                   (!neg_ff[QB] && q_ff[QB][QB-1]) ||
                   (neg_ff[QB] && q_ff[QB] > {1'b1, {(QB-1){1'b0}}})) begin
         elem_ff <= neg_ff[QB] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
         sat_ff  <= 1'b1;
      end else begin
         elem_ff <= neg_ff[QB] ? EW'(-q_ff[QB]) : EW'(q_ff[QB]);
         sat_ff  <= 1'b0;
      end
   end

   assign elem     = elem_ff;
   assign sat      = sat_ff;
   assign zero_det = dz_out_ff;

endmodule
`default_nettype wire

### design/matrix3x3_inverse.sv
`default_nettype none
// ---------------------------------------------------------------------------
// matrix3x3_inverse
// Pipelined inverse of a signed Q16.16 3x3 matrix through its adjugate.
// ---------------------------------------------------------------------------
// A new matrix may be started in every clock cycle and busy never rises.
// Each beat returns its inverse on rsp_data with rsp_strobe high for one
// cycle, in start order. The path runs through the 32 restoring division
// stages of the nine lanes, one quotient bit each, plus two cofactor,
// three determinant and two lane edge stages.
// The receiver cannot stall, so results must be taken when strobed.
module matrix3x3_inverse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire inv3_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output inv3_pkg::rsp_type      rsp_data
);
   import inv3_pkg::*;

   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   logic           accept;

   cof_type        cof_a [9];
   elem_type       row   [3];
   cof_type        cof_b [9];
   det_type        det;
   elem_type       b     [9];
   logic [8:0]     sat;
   logic [8:0]     dz;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   inv3_cof u_cof (
      .clock    (clock),
      .req_data (req_data),
      .cof      (cof_a),
      .row      (row)
   );

   inv3_det u_det (
      .clock (clock),
      .cof_i (cof_a),
      .row   (row),
      .cof_o (cof_b),
      .det   (det)
   );

   for (genvar i = 0; i < 9; i++) begin : g_lane
      inv3_div_lane u_lane (
         .clock    (clock),
         .cof      (cof_b[i]),
         .det      (det),
         .elem     (b[i]),
         .sat      (sat[i]),
         .zero_det (dz[i])
      );
   end

   assign rsp_strobe        = vld_ff[LAT-1];
   assign rsp_data.b00      = b[0];
   assign rsp_data.b01      = b[1];
   assign rsp_data.b02      = b[2];
   assign rsp_data.b10      = b[3];
   assign rsp_data.b11      = b[4];
   assign rsp_data.b12      = b[5];
   assign rsp_data.b20      = b[6];
   assign rsp_data.b21      = b[7];
   assign rsp_data.b22      = b[8];
   assign rsp_data.singular = dz[0];
   assign rsp_data.overflow = |sat;

   a_strobe_follows_start : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result beat without a start beat");

   a_singular_no_overflow : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.singular |-> !rsp_data.overflow)
      else $error("singular result flagged as overflow");

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.singular |->
         (rsp_data.b00 == '0) && (rsp_data.b11 == '0) && (rsp_data.b22 == '0))
      else $error("singular result with nonzero elements");

   a_lanes_agree : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (dz == '0) || (dz == '1))
      else $error("lanes disagree on a zero determinant");

endmodule
`default_nettype wire

### bench/matrix3x3_inverse_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// matrix3x3_inverse_tb
// Self-checking bench for the pipelined 3x3 adjugate inverse. Each started
// matrix is inverted by an exact wide-integer model of the block and queued;
// every strobed beat is compared field by field with the oldest entry.
// ---------------------------------------------------------------------------
module matrix3x3_inverse_tb;
   import inv3_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type inverse_queue[$];
   int      error_count;
   longint  cycle_count;

   matrix3x3_inverse u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type invert_matrix(req_type m);
      logic signed [255:0] a[9];
      logic signed [255:0] cof[9];
      logic signed [255:0] det;
      logic signed [255:0] num;
      logic signed [255:0] quo;
      logic signed [255:0] hi;
      logic signed [255:0] lo;
      elem_type            b[9];
      rsp_type             r;
      a[0] = m.a00; a[1] = m.a01; a[2] = m.a02;
      a[3] = m.a10; a[4] = m.a11; a[5] = m.a12;
      a[6] = m.a20; a[7] = m.a21; a[8] = m.a22;
      for (int k = 0; k < 9; k++) begin
         cof[k] = a[COF_IDX[k][0]] * a[COF_IDX[k][1]] - a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
      end
      det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      hi = (256'sd1 <<< (ELEM_WIDTH - 1)) - 1;
      lo = -(256'sd1 <<< (ELEM_WIDTH - 1));
      for (int k = 0; k < 9; k++) begin
         num = cof[k] <<< (2 * FRAC_BITS);
         quo = num / det;
         if (quo > hi) begin
            b[k] = hi[EW-1:0];
            r.overflow = 1'b1;
         end else if (quo < lo) begin
            b[k] = lo[EW-1:0];
            r.overflow = 1'b1;
         end else begin
            b[k] = quo[EW-1:0];
         end
      end
      r.b00 = b[0]; r.b01 = b[1]; r.b02 = b[2];
      r.b10 = b[3]; r.b11 = b[4]; r.b12 = b[5];
      r.b20 = b[6]; r.b21 = b[7]; r.b22 = b[8];
      return r;
   endfunction

   task automatic send_matrix(req_type m, int gap);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= m;
      do @(posedge clock); while (busy);
      inverse_queue = {inverse_queue, invert_matrix(m)};
   endtask

   function automatic elem_type pick_elem(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 16)) - 8;
         2: return ($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
         3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type  m;
      elem_type e[9];
      int       mode;
      mode = $urandom_range(0, 4);
      for (int k = 0; k < 9; k++) begin
         e[k] = ($urandom_range(0, 7) == 0) ? pick_elem($urandom_range(0, 4)) : pick_elem(mode);
      end
      if ($urandom_range(0, 9) == 0) begin
         for (int k = 0; k < 3; k++) e[6 + k] = e[3 + k];
      end
      m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
      return m;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (inverse_queue.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      elem_type one;
      elem_type mx;
      elem_type mn;
      one = 32'sd1 <<< FRAC_BITS;
      mx  = 32'sh7fffffff;
      mn  = 32'sh80000000;
      send_matrix({one, 32'sd0, 32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, one}, 0);
      send_matrix({one * 2, 32'sd0, 32'sd0, 32'sd0, -one, 32'sd0, 32'sd0, 32'sd0, one * 4}, 0);
      send_matrix('0, 0);
      send_matrix({9{one}}, 0);
      send_matrix({9{mx}}, 1);
      send_matrix({9{mn}}, 0);
      send_matrix({mn, 32'sd0, 32'sd0, 32'sd0, mn, 32'sd0, 32'sd0, 32'sd0, mn}, 0);
      send_matrix({mx, 32'sd0, 32'sd0, 32'sd0, mx, 32'sd0, 32'sd0, 32'sd0, mx}, 0);
      send_matrix({32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 2);
      send_matrix({-32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 0);
      send_matrix({mx, mn, mx, mn, mx, mn, mx, mn, mn}, 0);
      send_matrix({mn, mx, 32'sd0, mx, mn, 32'sd0, 32'sd0, 32'sd0, one}, 0);
      send_matrix({32'sd0, one, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, 32'sd0, one}, 0);
      send_matrix({one, one * 2, one * 3, one * 4, one * 5, one * 6, one * 7, one * 8,
                   one * 10}, 0);
      send_matrix({-one, 32'sd5, 32'sd0, 32'sd7, -one, 32'sd3, 32'sd0, 32'sd1, -one}, 0);
      send_matrix({32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh12345678,
                   32'shedcba987, 32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh00ff00ff,
                   32'shff00ff00}, 0);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         send_matrix(random_matrix(),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0);
         if (i == count / 2) wait_drained();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_type want;
         if (inverse_queue.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = inverse_queue.pop_front();
            if (rsp_data.b00 !== want.b00 || rsp_data.b01 !== want.b01 ||
                rsp_data.b02 !== want.b02 || rsp_data.b10 !== want.b10 ||
                rsp_data.b11 !== want.b11 || rsp_data.b12 !== want.b12 ||
                rsp_data.b20 !== want.b20 || rsp_data.b21 !== want.b21 ||
                rsp_data.b22 !== want.b22 || rsp_data.singular !== want.singular ||
                rsp_data.overflow !== want.overflow) begin
               $display("%0t: mismatch, expected %h, actual %h", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      cycle_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      wait_drained();
      test_random(1600);
      wait_drained();
      repeat (2 * LAT) @(negedge clock);
      if (error_count == 0 && inverse_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
design/inv3_pkg.sv
design/inv3_cof.sv
design/inv3_det.sv
design/inv3_div_lane.sv
design/matrix3x3_inverse.sv
bench/matrix3x3_inverse_tb.sv
